### rtl/core/sdfp_pkg.sv
// Package for the surround depth block: register indexes, constants, arccos table.
`default_nettype none
package sdfp_pkg;

  typedef enum logic [1:0] {
    REG_ZERO_ANGLE    = 2'd0,
    REG_HALF_ANGLE    = 2'd1,
    REG_FULL_ANGLE    = 2'd2,
    REG_NEAR_DISTANCE = 2'd3
  } reg_index_t;

  localparam logic [15:0] ZERO_ANGLE_RST    = 16'd16902;
  localparam logic [15:0] HALF_ANGLE_RST    = 16'd25736;
  localparam logic [15:0] FULL_ANGLE_RST    = 16'd34570;
  localparam logic [23:0] NEAR_DISTANCE_RST = 24'd3072;

  localparam logic [15:0] DEPTH_HALF = 16'd16384;
  localparam logic [15:0] DEPTH_ONE  = 16'd32768;
  localparam logic [6:0]  IDX_MAX    = 7'd100;
  localparam logic [5:0]  IDX_SCALE  = 6'd50;

  function automatic logic [15:0] acos_lut(input logic [6:0] i);
    logic [15:0] v;
    case (i)
      7'd0: v = 16'd51472;  7'd1: v = 16'd48190;  7'd2: v = 16'd46822;
      7'd3: v = 16'd45768;  7'd4: v = 16'd44874;  7'd5: v = 16'd44082;
      7'd6: v = 16'd43363;  7'd7: v = 16'd42698;  7'd8: v = 16'd42075;
      7'd9: v = 16'd41488;  7'd10: v = 16'd40929; 7'd11: v = 16'd40394;
      7'd12: v = 16'd39880; 7'd13: v = 16'd39385; 7'd14: v = 16'd38905;
      7'd15: v = 16'd38440; 7'd16: v = 16'd37987; 7'd17: v = 16'd37546;
      7'd18: v = 16'd37115; 7'd19: v = 16'd36693; 7'd20: v = 16'd36279;
      7'd21: v = 16'd35873; 7'd22: v = 16'd35474; 7'd23: v = 16'd35082;
      7'd24: v = 16'd34696; 7'd25: v = 16'd34315; 7'd26: v = 16'd33939;
      7'd27: v = 16'd33567; 7'd28: v = 16'd33200; 7'd29: v = 16'd32837;
      7'd30: v = 16'd32478; 7'd31: v = 16'd32122; 7'd32: v = 16'd31770;
      7'd33: v = 16'd31420; 7'd34: v = 16'd31073; 7'd35: v = 16'd30728;
      7'd36: v = 16'd30386; 7'd37: v = 16'd30045; 7'd38: v = 16'd29707;
      7'd39: v = 16'd29370; 7'd40: v = 16'd29035; 7'd41: v = 16'd28701;
      7'd42: v = 16'd28369; 7'd43: v = 16'd28037; 7'd44: v = 16'd27707;
      7'd45: v = 16'd27377; 7'd46: v = 16'd27048; 7'd47: v = 16'd26720;
      7'd48: v = 16'd26391; 7'd49: v = 16'd26064; 7'd50: v = 16'd25736;
      7'd51: v = 16'd25408; 7'd52: v = 16'd25080; 7'd53: v = 16'd24752;
      7'd54: v = 16'd24424; 7'd55: v = 16'd24095; 7'd56: v = 16'd23765;
      7'd57: v = 16'd23435; 7'd58: v = 16'd23103; 7'd59: v = 16'd22771;
      7'd60: v = 16'd22437; 7'd61: v = 16'd22102; 7'd62: v = 16'd21765;
      7'd63: v = 16'd21427; 7'd64: v = 16'd21086; 7'd65: v = 16'd20744;
      7'd66: v = 16'd20399; 7'd67: v = 16'd20052; 7'd68: v = 16'd19702;
      7'd69: v = 16'd19350; 7'd70: v = 16'd18994; 7'd71: v = 16'd18634;
      7'd72: v = 16'd18271; 7'd73: v = 16'd17904; 7'd74: v = 16'd17533;
      7'd75: v = 16'd17157; 7'd76: v = 16'd16776; 7'd77: v = 16'd16390;
      7'd78: v = 16'd15998; 7'd79: v = 16'd15599; 7'd80: v = 16'd15193;
      7'd81: v = 16'd14779; 7'd82: v = 16'd14357; 7'd83: v = 16'd13926;
      7'd84: v = 16'd13485; 7'd85: v = 16'd13032; 7'd86: v = 16'd12566;
      7'd87: v = 16'd12087; 7'd88: v = 16'd11591; 7'd89: v = 16'd11078;
      7'd90: v = 16'd10543; 7'd91: v = 16'd9984;  7'd92: v = 16'd9396;
      7'd93: v = 16'd8774;  7'd94: v = 16'd8109;  7'd95: v = 16'd7390;
      7'd96: v = 16'd6598;  7'd97: v = 16'd5704;  7'd98: v = 16'd4650;
      7'd99: v = 16'd3282;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

### rtl/core/surround_depth_from_position.sv
// Three restoring dividers (8, 14 and 14 stages) set the depth, one quotient
// bit per stage, save the index divider's first stage, which only flags
// saturation; one multiplier stage sits before the last divider. One item per
// cycle; the whole pipeline holds while the output is full and not taken.
// Reset (rst, synchronous) clears all valid bits and loads register defaults.
`default_nettype none
module surround_depth_from_position
  import sdfp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [23:0] y_position,
  input  wire logic [23:0] distance,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      depth,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [23:0] cfg_data
);

  localparam int S1 = 8;
  localparam int S2 = 14;
  localparam int S3 = 14;

  logic [15:0] zero_angle, half_angle, full_angle;
  logic [23:0] near_distance;

  logic en;
  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      zero_angle    <= ZERO_ANGLE_RST;
      half_angle    <= HALF_ANGLE_RST;
      full_angle    <= FULL_ANGLE_RST;
      near_distance <= NEAR_DISTANCE_RST;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_ZERO_ANGLE:    zero_angle    <= cfg_data[15:0];
        REG_HALF_ANGLE:    half_angle    <= cfg_data[15:0];
        REG_FULL_ANGLE:    full_angle    <= cfg_data[15:0];
        REG_NEAR_DISTANCE: near_distance <= cfg_data;
        default: ;
      endcase
    end
  end

  // front stages
  logic               v0;
  logic signed [25:0] diff0;
  logic [23:0]        d0;
  logic signed [31:0] prod0;
  assign prod0 = $signed(32'(diff0)) * $signed(32'(IDX_SCALE));

  // index divider
  logic        v1s [0:S1];
  logic [30:0] r1  [0:S1];
  logic [23:0] d1  [0:S1];
  logic [6:0]  q1  [0:S1];
  logic        sat1[0:S1];
  logic [30:0] r1_next  [1:S1];
  logic [6:0]  q1_next  [1:S1];
  logic        sat1_next[1:S1];

  always_comb begin
    logic [31:0] dsh;
    for (int j = 0; j < S1; j++) begin
      dsh = 32'(d1[j]) << (S1 - 1 - j);
      r1_next[j+1]   = r1[j];
      q1_next[j+1]   = q1[j];
      sat1_next[j+1] = sat1[j];
      if (j == 0) begin
        if (32'(r1[j]) >= dsh) sat1_next[j+1] = 1'b1;
      end else if (!sat1[j] && 32'(r1[j]) >= dsh) begin
        r1_next[j+1] = 31'(32'(r1[j]) - dsh);
        q1_next[j+1][S1-1-j] = 1'b1;
      end
    end
  end

  logic [6:0] idx;
  assign idx = (sat1[S1] || q1[S1] > IDX_MAX) ? IDX_MAX : q1[S1];

  // angle and ramp select
  logic        va;
  logic [15:0] ang;
  logic [23:0] da;

  // ramp divider
  logic        v2s [0:S2];
  logic [29:0] r2  [0:S2];
  logic [15:0] dn2 [0:S2];
  logic [13:0] q2  [0:S2];
  logic [15:0] b2  [0:S2];
  logic [23:0] d2  [0:S2];
  logic [29:0] r2_next[1:S2];
  logic [13:0] q2_next[1:S2];

  always_comb begin
    logic [29:0] dsh;
    for (int j = 0; j < S2; j++) begin
      dsh = 30'(dn2[j]) << (S2 - 1 - j);
      r2_next[j+1] = r2[j];
      q2_next[j+1] = q2[j];
      if (r2[j] >= dsh) begin
        r2_next[j+1] = r2[j] - dsh;
        q2_next[j+1][S2-1-j] = 1'b1;
      end
    end
  end

  logic [15:0] dep2;
  assign dep2 = b2[S2] + 16'(q2[S2]);

  // blend multiply
  logic [16:0] dd;
  logic [14:0] mag;
  assign dd  = {1'b0, dep2} - {1'b0, DEPTH_HALF};
  assign mag = dd[16] ? 15'(-dd) : 15'(dd);

  // blend divider
  logic        v3s [0:S3];
  logic [38:0] r3  [0:S3];
  logic [13:0] q3  [0:S3];
  logic        n3  [0:S3];
  logic        bl3 [0:S3];
  logic [15:0] dp3 [0:S3];
  logic [38:0] r3_next[1:S3];
  logic [13:0] q3_next[1:S3];

  always_comb begin
    logic [38:0] dsh;
    for (int j = 0; j < S3; j++) begin
      dsh = 39'(near_distance) << (S3 - 1 - j);
      r3_next[j+1] = r3[j];
      q3_next[j+1] = q3[j];
      if (r3[j] >= dsh) begin
        r3_next[j+1] = r3[j] - dsh;
        q3_next[j+1][S3-1-j] = 1'b1;
      end
    end
  end

  logic [15:0] res;
  always_comb begin
    if (!bl3[S3]) res = dp3[S3];
    else if (n3[S3]) res = DEPTH_HALF - 16'(q3[S3]);
    else res = DEPTH_HALF + 16'(q3[S3]);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0; va <= 1'b0;
      out_valid <= 1'b0;
      for (int j = 0; j <= S1; j++) v1s[j] <= 1'b0;
      for (int j = 0; j <= S2; j++) v2s[j] <= 1'b0;
      for (int j = 0; j <= S3; j++) v3s[j] <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1s[0] <= v0;
      for (int j = 1; j <= S1; j++) v1s[j] <= v1s[j-1];
      va <= v1s[S1];
      v2s[0] <= va;
      for (int j = 1; j <= S2; j++) v2s[j] <= v2s[j-1];
      v3s[0] <= v2s[S2];
      for (int j = 1; j <= S3; j++) v3s[j] <= v3s[j-1];
      out_valid <= v3s[S3];
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (en) begin
      diff0 <= $signed({2'b00, distance}) - $signed({{2{y_position[23]}}, y_position});
      d0    <= distance;

      r1[0]   <= (prod0 > 32'sd0) ? prod0[30:0] : 31'd0;
      d1[0]   <= d0;
      q1[0]   <= 7'd0;
      sat1[0] <= 1'b0;
      for (int j = 1; j <= S1; j++) begin
        r1[j]   <= r1_next[j];
        q1[j]   <= q1_next[j];
        sat1[j] <= sat1_next[j];
        d1[j]   <= d1[j-1];
      end

      ang <= acos_lut(idx);
      da  <= d1[S1];

      d2[0] <= da;
      if (ang < zero_angle) begin
        b2[0] <= 16'd0; r2[0] <= 30'd0; dn2[0] <= 16'd1;
      end else if (ang < half_angle) begin
        b2[0] <= 16'd0; r2[0] <= {ang - zero_angle, 14'd0};
        dn2[0] <= half_angle - zero_angle;
      end else if (ang < full_angle) begin
        b2[0] <= DEPTH_HALF; r2[0] <= {ang - half_angle, 14'd0};
        dn2[0] <= full_angle - half_angle;
      end else begin
        b2[0] <= DEPTH_ONE; r2[0] <= 30'd0; dn2[0] <= 16'd1;
      end
      q2[0] <= 14'd0;
      for (int j = 1; j <= S2; j++) begin
        r2[j]  <= r2_next[j];
        q2[j]  <= q2_next[j];
        dn2[j] <= dn2[j-1];
        b2[j]  <= b2[j-1];
        d2[j]  <= d2[j-1];
      end

      r3[0]  <= 39'(mag) * 39'(d2[S2]);
      q3[0]  <= 14'd0;
      n3[0]  <= dd[16];
      bl3[0] <= d2[S2] < near_distance;
      dp3[0] <= dep2;
      for (int j = 1; j <= S3; j++) begin
        r3[j]  <= r3_next[j];
        q3[j]  <= q3_next[j];
        n3[j]  <= n3[j-1];
        bl3[j] <= bl3[j-1];
        dp3[j] <= dp3[j-1];
      end

      depth <= res;
    end
  end

  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> depth <= DEPTH_ONE) else $error("depth above one");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready)) else $error("ready mismatch");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(depth)) else $error("result lost");
  a_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid) else $error("valid after reset");

endmodule
`default_nettype wire

### tb/testbench.sv
// Testbench for the surround depth block: directed and random sources against a built-in depth predictor.
module testbench;
  import sdfp_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [23:0] y_position = '0;
  logic [23:0] distance = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [15:0] depth;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [23:0] cfg_data = '0;

  surround_depth_from_position uut (.*);

  typedef struct packed {
    logic        is_cfg;
    logic [1:0]  index;
    logic [23:0] y;
    logic [23:0] d;
  } source_t;

  source_t pending[$];
  logic [15:0] depth_expected[$];
  logic [15:0] zero_ang, half_ang, full_ang;
  logic [23:0] near_dist;
  int errors = 0;
  int sources_sent = 0;
  int depths_seen = 0;
  int quiet_cycles = 0;
  int cycle = 0;
  bit driving_done = 1'b0;

  initial forever #2 clk = ~clk;

  function automatic logic [15:0] rom_angle(input int i);
    int t[101] = '{
      51472, 48190, 46822, 45768, 44874, 44082, 43363, 42698, 42075, 41488,
      40929, 40394, 39880, 39385, 38905, 38440, 37987, 37546, 37115, 36693,
      36279, 35873, 35474, 35082, 34696, 34315, 33939, 33567, 33200, 32837,
      32478, 32122, 31770, 31420, 31073, 30728, 30386, 30045, 29707, 29370,
      29035, 28701, 28369, 28037, 27707, 27377, 27048, 26720, 26391, 26064,
      25736, 25408, 25080, 24752, 24424, 24095, 23765, 23435, 23103, 22771,
      22437, 22102, 21765, 21427, 21086, 20744, 20399, 20052, 19702, 19350,
      18994, 18634, 18271, 17904, 17533, 17157, 16776, 16390, 15998, 15599,
      15193, 14779, 14357, 13926, 13485, 13032, 12566, 12087, 11591, 11078,
      10543, 9984, 9396, 8774, 8109, 7390, 6598, 5704, 4650, 3282, 0};
    return t[i][15:0];
  endfunction

  function automatic logic [15:0] predict_depth(input logic [23:0] yp, input logic [23:0] dp);
    longint y, d, ang, dep, num, idx, za, ha, fa, nd;
    y = longint'(signed'(yp));
    d = longint'(dp);
    za = zero_ang; ha = half_ang; fa = full_ang; nd = near_dist;
    ang = 0;
    if (d > 0) begin
      num = 50 * (d - y);
      idx = (num > 0) ? num / d : 0;
      if (idx > 100) idx = 100;
      ang = rom_angle(int'(idx));
    end
    if (ang < za) dep = 0;
    else if (ang < ha) dep = (16384 * (ang - za)) / (ha - za);
    else if (ang < fa) dep = 16384 + (16384 * (ang - ha)) / (fa - ha);
    else dep = 32768;
    if (d < nd) dep = 16384 + ((dep - 16384) * d) / nd;
    if (dep > 32768) dep = 32768;
    if (dep < 0) dep = 0;
    return dep[15:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got, input logic [15:0] want);
    errors++;
    $display("tb: mismatch %s got %0d expected %0d at cycle %0d", what, got, want, cycle);
  endtask

  function automatic void push_cfg(input reg_index_t r, input logic [23:0] v);
    source_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.index = r;
    s.y = v;
    pending.push_back(s);
  endfunction

  function automatic void push_src(input logic [23:0] yp, input logic [23:0] dp);
    source_t s;
    s = '0;
    s.y = yp;
    s.d = dp;
    pending.push_back(s);
  endfunction

  function automatic void push_random(input int n);
    int k;
    logic [23:0] dd;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 5))
        0: dd = 24'($urandom);
        1: dd = 24'($urandom_range(0, 8000));
        2: dd = $urandom_range(0, 1) ? 24'hFFFFFF : 24'd0;
        default: dd = 24'($urandom_range(1, 200000));
      endcase
      case ($urandom_range(0, 3))
        0: push_src(24'($urandom), dd);
        1: push_src(24'(-int'(dd) + $urandom_range(0, 2 * dd)), dd);
        2: push_src($urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000, dd);
        default: push_src(24'(int'($urandom_range(0, 2 * dd)) - int'(dd)), dd);
      endcase
    end
  endfunction

  // phase marker: wait for drain before applying next settings
  localparam source_t DRAIN = '{is_cfg: 1'b1, index: 2'd0, y: 24'hFFFFFF, d: 24'hFFFFFF};

  initial begin
    int p;
    push_src(24'h000000, 24'h000000);
    push_src(24'h7FFFFF, 24'h000000);
    push_src(24'h800000, 24'hFFFFFF);
    push_src(24'h7FFFFF, 24'hFFFFFF);
    push_src(24'h800000, 24'h000001);
    push_src(24'h7FFFFF, 24'h000001);
    push_src(24'h000000, 24'h000C00);
    push_src(24'h000000, 24'h000BFF);
    push_src(24'h000100, 24'h000100);
    push_src(24'hFFFF00, 24'h000100);
    push_src(24'h000064, 24'h0000C8);
    push_src(24'h000000, 24'h010000);
    push_src(24'hFF8000, 24'h008000);
    push_src(24'h555555, 24'hAAAAAA);
    push_src(24'hAAAAAA, 24'h555555);
    push_random(250);
    for (p = 0; p < 7; p++) begin
      pending.push_back(DRAIN);
      case (p)
        0: begin
          push_cfg(REG_ZERO_ANGLE, 24'd0); push_cfg(REG_HALF_ANGLE, 24'd0);
          push_cfg(REG_FULL_ANGLE, 24'd0); push_cfg(REG_NEAR_DISTANCE, 24'd1);
        end
        1: begin
          push_cfg(REG_ZERO_ANGLE, 24'd51472); push_cfg(REG_HALF_ANGLE, 24'd51472);
          push_cfg(REG_FULL_ANGLE, 24'd51472); push_cfg(REG_NEAR_DISTANCE, 24'hFFFFFF);
        end
        2: begin
          push_cfg(REG_ZERO_ANGLE, 24'd40000); push_cfg(REG_HALF_ANGLE, 24'd20000);
          push_cfg(REG_FULL_ANGLE, 24'd10000); push_cfg(REG_NEAR_DISTANCE, 24'd0);
        end
        3: begin
          push_cfg(REG_ZERO_ANGLE, 24'hFFFFFF); push_cfg(REG_HALF_ANGLE, 24'h00FFFF);
          push_cfg(REG_FULL_ANGLE, 24'hFF0000); push_cfg(REG_NEAR_DISTANCE, 24'd100000);
        end
        default: begin
          push_cfg(REG_ZERO_ANGLE, 24'($urandom_range(0, 51472)));
          push_cfg(REG_HALF_ANGLE, 24'($urandom_range(0, 51472)));
          push_cfg(REG_FULL_ANGLE, 24'($urandom_range(0, 51472)));
          push_cfg(REG_NEAR_DISTANCE,
                   24'($urandom_range(0, 1) ? $urandom : $urandom_range(1, 70000)));
        end
      endcase
      push_random(240);
    end
    pending.push_back(DRAIN);
    push_cfg(REG_ZERO_ANGLE, 24'(ZERO_ANGLE_RST)); push_cfg(REG_HALF_ANGLE, 24'(HALF_ANGLE_RST));
    push_cfg(REG_FULL_ANGLE, 24'(FULL_ANGLE_RST)); push_cfg(REG_NEAR_DISTANCE, NEAR_DISTANCE_RST);
    push_random(20);
  end

  function automatic bit calm(input int c);
    return (c % 3000) < 500;
  endfunction

  int drain_wait = 0;

  // driver
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle == 7) rst <= 1'b0;
    if (!rst) begin
      if (in_valid && in_ready) sources_sent <= sources_sent + 1;
      if ((in_valid && !in_ready) || (cfg_valid && !cfg_ready)) begin
      end else if (pending.size() == 0) begin
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
        driving_done <= 1'b1;
      end else if (pending[0] == DRAIN) begin
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
        if (depth_expected.size() == 0 && !(in_valid && in_ready)) begin
          if (drain_wait >= 60) begin
            void'(pending.pop_front());
            drain_wait <= 0;
          end else begin
            drain_wait <= drain_wait + 1;
          end
        end else begin
          drain_wait <= 0;
        end
      end else if (calm(cycle) || $urandom_range(0, 99) >= 36) begin
        if (pending[0].is_cfg) begin
          in_valid <= 1'b0;
          cfg_valid <= 1'b1;
          cfg_index <= pending[0].index;
          cfg_data <= pending[0].y;
        end else begin
          cfg_valid <= 1'b0;
          in_valid <= 1'b1;
          y_position <= pending[0].y;
          distance <= pending[0].d;
        end
        void'(pending.pop_front());
      end else begin
        in_valid <= 1'b0;
        cfg_valid <= 1'b0;
      end
      out_ready <= calm(cycle + 1500) || $urandom_range(0, 99) >= 36;
    end
  end

  // monitor and predictor
  always @(posedge clk) begin
    if (rst) begin
      zero_ang <= ZERO_ANGLE_RST;
      half_ang <= HALF_ANGLE_RST;
      full_ang <= FULL_ANGLE_RST;
      near_dist <= NEAR_DISTANCE_RST;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_ZERO_ANGLE: zero_ang <= cfg_data[15:0];
          REG_HALF_ANGLE: half_ang <= cfg_data[15:0];
          REG_FULL_ANGLE: full_ang <= cfg_data[15:0];
          REG_NEAR_DISTANCE: near_dist <= cfg_data;
        endcase
      end
      if (in_valid && in_ready) depth_expected.push_back(predict_depth(y_position, distance));
      if (out_valid && out_ready) begin
        depths_seen <= depths_seen + 1;
        if (depth_expected.size() == 0) report_mismatch("unexpected depth", depth, 16'd0);
        else begin
          if (depth !== depth_expected[0]) report_mismatch("depth", depth, depth_expected[0]);
          void'(depth_expected.pop_front());
        end
      end
    end
  end

  // watchdog and end of run
  initial begin
    int tail;
    tail = 0;
    @(negedge rst);
    while (!(driving_done && depth_expected.size() == 0 && tail > 60)) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles > 2000) begin
        $display("tb: timeout with %0d depths outstanding", depth_expected.size());
        $display("tb: failure");
        $finish;
      end
      tail = (driving_done && depth_expected.size() == 0) ? tail + 1 : 0;
    end
    $display("tb: %0d sources sent, %0d depths checked, %0d mismatches", sources_sent,
             depths_seen, errors);
    $display("tb: covered reset, extreme and disordered angle settings, zero near distance");
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
